/* sv/clst_pkg.sv */
// shared types, constants and lookup functions for the c-like source tokenizer
// no dependencies; imported by c_like_source_tokenizer

package clst_pkg;

  localparam int KW_BYTES = 7;
  localparam int KW_COUNT = 21;
  localparam int POS_BITS = 24;
  localparam int LINE_BITS = 16;
  localparam int COL_BITS = 16;
  localparam int KIND_BITS = 6;
  localparam int ERR_BITS = 3;
  localparam int KWLEN_BITS = 3;

  localparam logic [POS_BITS-1:0] POS_MAX = '1;
  localparam logic [LINE_BITS-1:0] LINE_MAX = '1;
  localparam logic [COL_BITS-1:0] COL_MAX = '1;

  localparam logic [KIND_BITS-1:0] K_IDENT = 6'd6;
  localparam logic [KIND_BITS-1:0] K_INTLIT = 6'd7;
  localparam logic [KIND_BITS-1:0] K_FLOATLIT = 6'd8;
  localparam logic [KIND_BITS-1:0] K_STRLIT = 6'd9;
  localparam logic [KIND_BITS-1:0] K_CHARLIT = 6'd10;
  localparam logic [KIND_BITS-1:0] K_DIVIDE = 6'd31;
  localparam logic [KIND_BITS-1:0] K_LCOM = 6'd52;
  localparam logic [KIND_BITS-1:0] K_BCOM = 6'd53;
  localparam logic [KIND_BITS-1:0] K_ERROR = 6'd54;
  localparam logic [KIND_BITS-1:0] K_EOF = 6'd55;
  localparam logic [KIND_BITS-1:0] K_NONE = 6'd63;

  localparam logic [ERR_BITS-1:0] E_NONE = 3'd0;
  localparam logic [ERR_BITS-1:0] E_OPEN_COMMENT = 3'd1;
  localparam logic [ERR_BITS-1:0] E_OPEN_LITERAL = 3'd2;
  localparam logic [ERR_BITS-1:0] E_BAD_NUMBER = 3'd3;
  localparam logic [ERR_BITS-1:0] E_UNEXPECTED = 3'd4;

  typedef struct packed {
    logic [7:0] source_byte;
    logic       end_of_input;
  } src_item_t;

  typedef struct packed {
    logic [KIND_BITS-1:0] token_kind;
    logic [LINE_BITS-1:0] token_line;
    logic [COL_BITS-1:0]  token_column;
    logic [POS_BITS-1:0]  start_offset;
    logic [POS_BITS-1:0]  token_length;
    logic [ERR_BITS-1:0]  error_kind;
    logic                 last;
  } tok_item_t;

  // keyword text is right-justified, first byte highest
  localparam logic [KW_BYTES*8-1:0] KW_TEXT [KW_COUNT] = '{
    "int", "float", "double", "char", "void", "bool", "true", "false",
    "if", "else", "while", "return", "print", "main", "string", "do",
    "switch", "break", "for", "default", "case"
  };
  localparam logic [KWLEN_BITS-1:0] KW_LEN [KW_COUNT] = '{
    3'd3, 3'd5, 3'd6, 3'd4, 3'd4, 3'd4, 3'd4, 3'd5, 3'd2, 3'd4, 3'd5,
    3'd6, 3'd5, 3'd4, 3'd6, 3'd2, 3'd6, 3'd5, 3'd3, 3'd7, 3'd4
  };
  localparam logic [KIND_BITS-1:0] KW_KIND [KW_COUNT] = '{
    6'd0, 6'd1, 6'd2, 6'd3, 6'd4, 6'd5, 6'd11, 6'd11, 6'd38, 6'd39, 6'd40,
    6'd41, 6'd42, 6'd43, 6'd44, 6'd45, 6'd46, 6'd47, 6'd48, 6'd49, 6'd50
  };

  // buffer byte i sits at bits [i*8 +: 8]
  function automatic logic [KIND_BITS-1:0] kw_kind(
    input logic [KW_BYTES*8-1:0] kbuf,
    input logic [KWLEN_BITS-1:0] len
  );
    logic [KIND_BITS-1:0] kind;
    logic                 hit;
    kind = K_IDENT;
    for (int e = 0; e < KW_COUNT; e++) begin
      hit = (KW_LEN[e] == len);
      for (int i = 0; i < KW_BYTES; i++) begin
        if (i < int'(KW_LEN[e]))
          hit = hit & (kbuf[i*8 +: 8] ==
                       KW_TEXT[e][(int'(KW_LEN[e]) - 1 - i)*8 +: 8]);
      end
      if (hit && kind == K_IDENT) kind = KW_KIND[e];
    end
    return kind;
  endfunction

  function automatic logic [KIND_BITS-1:0] single_kind(input logic [7:0] b);
    case (b)
      "(":     return 6'd12;
      ")":     return 6'd13;
      "{":     return 6'd14;
      "}":     return 6'd15;
      "[":     return 6'd16;
      "]":     return 6'd17;
      ";":     return 6'd18;
      ",":     return 6'd19;
      ".":     return 6'd20;
      "=":     return 6'd21;
      "<":     return 6'd24;
      ">":     return 6'd25;
      "+":     return 6'd28;
      "-":     return 6'd29;
      "*":     return 6'd30;
      "/":     return 6'd31;
      "%":     return 6'd32;
      "!":     return 6'd37;
      ":":     return 6'd51;
      default: return K_NONE;
    endcase
  endfunction

  function automatic logic [KIND_BITS-1:0] pair_kind(input logic [7:0] a,
                                                     input logic [7:0] b);
    logic [KIND_BITS-1:0] k;
    k = K_NONE;
    if (a == "=" && b == "=") k = 6'd22;
    if (a == "!" && b == "=") k = 6'd23;
    if (a == "<" && b == "=") k = 6'd26;
    if (a == ">" && b == "=") k = 6'd27;
    if (a == "+" && b == "+") k = 6'd33;
    if (a == "-" && b == "-") k = 6'd34;
    if (a == "&" && b == "&") k = 6'd35;
    if (a == "|" && b == "|") k = 6'd36;
    return k;
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return b inside {["0":"9"]};
  endfunction

  function automatic logic is_ident_start(input logic [7:0] b);
    return b inside {["a":"z"], ["A":"Z"], "_"} || b[7];
  endfunction

  function automatic logic is_space(input logic [7:0] b);
    return b inside {" ", 8'h09, 8'h0A, 8'h0D};
  endfunction

  function automatic logic is_pair_start(input logic [7:0] b);
    return b inside {"=", "!", "<", ">", "&", "|", "+", "-"};
  endfunction

endpackage

/* sv/c_like_source_tokenizer.sv */
// c-like source tokenizer: byte stream in, token records out
// depends on clst_pkg (types, keyword table, character classes)

// Takes one source byte per cycle while src_ready is high and produces token
// records (kind, line, start column, start offset, length, error kind). Each
// byte is fully handled in the cycle it is accepted; its zero, one or two
// tokens go into a four-entry output queue, and src_ready stays high while
// the queue has room for two tokens. With the output side always ready the
// block takes a byte every cycle; a byte that closes one token and opens
// another yields two tokens, so a long run of such bytes drains at one token
// per cycle. Tokens reach tok_valid through the registered output queue.
// A byte with end_of_input set flushes the open token, emits end of file and
// returns the scanner state (mode, line, column, position) to reset values.

module c_like_source_tokenizer
  import clst_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      src_valid,
  output logic      src_ready,
  input  src_item_t src_item,
  output logic      tok_valid,
  input  logic      tok_ready,
  output tok_item_t tok_item
);

  localparam logic [3:0] M_IDLE   = 4'd0;
  localparam logic [3:0] M_SLASH  = 4'd1;
  localparam logic [3:0] M_OP     = 4'd2;
  localparam logic [3:0] M_LCOM   = 4'd3;
  localparam logic [3:0] M_BCOM   = 4'd4;
  localparam logic [3:0] M_BSTAR  = 4'd5;
  localparam logic [3:0] M_QUOTE  = 4'd6;
  localparam logic [3:0] M_QESC   = 4'd7;
  localparam logic [3:0] M_NUM    = 4'd8;
  localparam logic [3:0] M_BADNUM = 4'd9;
  localparam logic [3:0] M_IDENT  = 4'd10;

  logic [3:0]           mode, mode_next;
  logic [7:0]           pend, pend_next;
  logic [LINE_BITS-1:0] line, line_next;
  logic [COL_BITS-1:0]  col, col_next;
  logic [POS_BITS-1:0]  pos, pos_next;
  logic [POS_BITS-1:0]  spos, spos_next;
  logic [COL_BITS-1:0]  scol, scol_next;
  logic                 frac, frac_next;
  logic                 qdbl, qdbl_next;
  logic [7:0]           kbuf [KW_BYTES];
  logic [KW_BYTES*8-1:0] kbuf_flat;

  logic                 kw_we;
  logic [KWLEN_BITS-1:0] kw_idx;

  tok_item_t            res [2];
  logic [1:0]           nres;

  tok_item_t            queue [4];
  logic [1:0]           rd_ptr, wr_ptr;
  logic [2:0]           count;

  logic                 src_fire, tok_fire;

  assign src_fire  = src_valid & src_ready;
  assign tok_fire  = tok_valid & tok_ready;
  assign src_ready = (count <= 3'd2);
  assign tok_valid = (count != 3'd0);
  assign tok_item  = queue[rd_ptr];

  always_comb begin
    for (int i = 0; i < KW_BYTES; i++) kbuf_flat[i*8 +: 8] = kbuf[i];
  end

  function automatic logic [POS_BITS-1:0] tok_len(input logic [POS_BITS-1:0] e,
                                                  input logic [POS_BITS-1:0] s);
    return (e >= s) ? e - s : '0;
  endfunction

  function automatic tok_item_t mk(input logic [KIND_BITS-1:0] kind,
                                   input logic [LINE_BITS-1:0] ln,
                                   input logic [COL_BITS-1:0]  c,
                                   input logic [POS_BITS-1:0]  off,
                                   input logic [POS_BITS-1:0]  len,
                                   input logic [ERR_BITS-1:0]  err);
    tok_item_t t;
    t.token_kind   = kind;
    t.token_line   = ln;
    t.token_column = c;
    t.start_offset = off;
    t.token_length = len;
    t.error_kind   = err;
    t.last         = 1'b0;
    return t;
  endfunction

  always_comb begin
    logic [7:0]           b;
    logic                 do_flush, do_begin, escaped;
    logic [POS_BITS-1:0]  pnext, idlen;
    logic [KIND_BITS-1:0] k;
    tok_item_t            t;
    logic                 emit_f;

    b = src_item.source_byte;
    pnext = (pos != POS_MAX) ? pos + 1'b1 : pos;
    idlen = pos - spos;
    do_flush = 1'b0;
    do_begin = 1'b0;
    escaped = 1'b0;
    emit_f = 1'b0;
    k = K_NONE;
    t = mk(K_NONE, line, scol, spos, '0, E_NONE);

    mode_next = mode;
    pend_next = pend;
    line_next = line;
    col_next = col;
    pos_next = pos;
    spos_next = spos;
    scol_next = scol;
    frac_next = frac;
    qdbl_next = qdbl;
    kw_we = 1'b0;
    kw_idx = '0;
    nres = 2'd0;
    res[0] = t;
    res[1] = t;

    if (src_item.end_of_input) begin
      do_flush = 1'b1;
    end else begin
      case (mode)
        M_IDLE: do_begin = 1'b1;
        M_SLASH: begin
          if (b == "/") mode_next = M_LCOM;
          else if (b == "*") mode_next = M_BCOM;
          else begin
            do_flush = 1'b1;
            do_begin = 1'b1;
          end
        end
        M_OP: begin
          k = pair_kind(pend, b);
          if (k != K_NONE) begin
            res[0] = mk(k, line, scol, spos, tok_len(pnext, spos), E_NONE);
            nres = 2'd1;
            mode_next = M_IDLE;
          end else begin
            do_flush = 1'b1;
            do_begin = 1'b1;
          end
        end
        M_LCOM: begin
          if (b == 8'h0A) begin
            do_flush = 1'b1;
            do_begin = 1'b1;
          end
        end
        M_BCOM: if (b == "*") mode_next = M_BSTAR;
        M_BSTAR: begin
          if (b == "/") begin
            res[0] = mk(K_BCOM, line, scol, spos, tok_len(pnext, spos), E_NONE);
            nres = 2'd1;
            mode_next = M_IDLE;
          end else if (b != "*") begin
            mode_next = M_BCOM;
          end
        end
        M_QUOTE: begin
          if (b == "\\") mode_next = M_QESC;
          else if (b == (qdbl ? 8'h22 : 8'h27)) begin
            res[0] = mk(qdbl ? K_STRLIT : K_CHARLIT, line, scol, spos,
                        tok_len(pnext, spos), E_NONE);
            nres = 2'd1;
            mode_next = M_IDLE;
          end
        end
        M_QESC: begin
          escaped = 1'b1;
          mode_next = M_QUOTE;
        end
        M_NUM: begin
          if (is_digit(b) || b inside {".", "e", "E", "+", "-"}) begin
            if (b inside {".", "e", "E"}) frac_next = 1'b1;
          end else if (is_ident_start(b)) begin
            mode_next = M_BADNUM;
          end else begin
            do_flush = 1'b1;
            do_begin = 1'b1;
          end
        end
        M_BADNUM: begin
          if (!(is_ident_start(b) || is_digit(b))) begin
            do_flush = 1'b1;
            do_begin = 1'b1;
          end
        end
        M_IDENT: begin
          if (is_ident_start(b) || is_digit(b)) begin
            if (idlen < POS_BITS'(KW_BYTES)) begin
              kw_we = 1'b1;
              kw_idx = idlen[KWLEN_BITS-1:0];
            end
          end else begin
            do_flush = 1'b1;
            do_begin = 1'b1;
          end
        end
        default: do_begin = 1'b1;
      endcase
    end

    // close the open token, ending just before the current byte
    if (do_flush) begin
      emit_f = 1'b1;
      case (mode)
        M_SLASH: t = mk(K_DIVIDE, line, scol, spos, tok_len(pos, spos), E_NONE);
        M_OP: begin
          k = single_kind(pend);
          if (k != K_NONE) t = mk(k, line, scol, spos, tok_len(pos, spos), E_NONE);
          else t = mk(K_ERROR, line, scol, spos, tok_len(pos, spos), E_UNEXPECTED);
        end
        M_LCOM: t = mk(K_LCOM, line, scol, spos, tok_len(pos, spos), E_NONE);
        M_BCOM, M_BSTAR:
          t = mk(K_ERROR, line, scol, spos, tok_len(pos, spos), E_OPEN_COMMENT);
        M_QUOTE, M_QESC:
          t = mk(K_ERROR, line, scol, spos, tok_len(pos, spos), E_OPEN_LITERAL);
        M_NUM: t = mk(frac ? K_FLOATLIT : K_INTLIT, line, scol, spos,
                      tok_len(pos, spos), E_NONE);
        M_BADNUM: t = mk(K_ERROR, line, scol, spos, tok_len(pos, spos), E_BAD_NUMBER);
        M_IDENT: t = mk((idlen > POS_BITS'(KW_BYTES)) ? K_IDENT
                          : kw_kind(kbuf_flat, idlen[KWLEN_BITS-1:0]),
                        line, scol, spos, tok_len(pos, spos), E_NONE);
        default: emit_f = 1'b0;
      endcase
      if (emit_f) begin
        res[0] = t;
        nres = 2'd1;
      end
      mode_next = M_IDLE;
    end

    if (src_item.end_of_input) begin
      res[nres[0]] = mk(K_EOF, line, col, pos, '0, E_NONE);
      nres = nres + 2'd1;
      mode_next = M_IDLE;
      pend_next = '0;
      line_next = LINE_BITS'(1);
      col_next = COL_BITS'(1);
      pos_next = '0;
      spos_next = '0;
      scol_next = COL_BITS'(1);
      frac_next = 1'b0;
      qdbl_next = 1'b0;
    end else begin
      if (do_begin) begin
        mode_next = M_IDLE;
        spos_next = pos;
        scol_next = col;
        k = single_kind(b);
        if (is_space(b)) begin
          mode_next = M_IDLE;
        end else if (b == "/") begin
          mode_next = M_SLASH;
        end else if (b == 8'h22 || b == 8'h27) begin
          mode_next = M_QUOTE;
          qdbl_next = (b == 8'h22);
        end else if (is_pair_start(b)) begin
          mode_next = M_OP;
          pend_next = b;
        end else if (k != K_NONE) begin
          res[nres[0]] = mk(k, line, col, pos, tok_len(pnext, pos), E_NONE);
          nres = nres + 2'd1;
        end else if (is_digit(b)) begin
          mode_next = M_NUM;
          frac_next = 1'b0;
        end else if (is_ident_start(b)) begin
          mode_next = M_IDENT;
          kw_we = 1'b1;
          kw_idx = '0;
        end else begin
          res[nres[0]] = mk(K_ERROR, line, col, pos, tok_len(pnext, pos), E_UNEXPECTED);
          nres = nres + 2'd1;
        end
      end
      // counters; an escaped newline only moves the column
      if (b == 8'h0A && !escaped) begin
        if (line != LINE_MAX) line_next = line + 1'b1;
        col_next = COL_BITS'(1);
      end else if (col != COL_MAX) begin
        col_next = col + 1'b1;
      end
      pos_next = pnext;
    end

    if (nres == 2'd1) res[0].last = 1'b1;
    if (nres == 2'd2) res[1].last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= M_IDLE;
      pend <= '0;
      line <= LINE_BITS'(1);
      col <= COL_BITS'(1);
      pos <= '0;
      spos <= '0;
      scol <= COL_BITS'(1);
      frac <= 1'b0;
      qdbl <= 1'b0;
    end else if (src_fire) begin
      mode <= mode_next;
      pend <= pend_next;
      line <= line_next;
      col <= col_next;
      pos <= pos_next;
      spos <= spos_next;
      scol <= scol_next;
      frac <= frac_next;
      qdbl <= qdbl_next;
    end
  end

  always_ff @(posedge clk) begin
    if (src_fire && kw_we) kbuf[kw_idx] <= src_item.source_byte;
  end

  // output queue: up to two pushes and one pop per cycle
  always_ff @(posedge clk) begin
    if (src_fire) begin
      if (nres != 2'd0) queue[wr_ptr] <= res[0];
      if (nres == 2'd2) queue[wr_ptr + 2'd1] <= res[1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count <= '0;
    end else begin
      if (tok_fire) rd_ptr <= rd_ptr + 2'd1;
      if (src_fire) wr_ptr <= wr_ptr + nres;
      count <= count + (src_fire ? {1'b0, nres} : 3'd0) - (tok_fire ? 3'd1 : 3'd0);
    end
  end

  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    count <= 3'd4) else $error("token queue overflow");

  a_eof_resets: assert property (@(posedge clk) disable iff (rst)
    src_fire && src_item.end_of_input |=> mode == M_IDLE && pos == '0 && line == 16'd1)
    else $error("end of input did not restore reset state");

  a_start_behind: assert property (@(posedge clk) disable iff (rst)
    spos <= pos) else $error("token start ahead of position");

  a_eof_last: assert property (@(posedge clk) disable iff (rst)
    tok_valid && tok_item.token_kind == K_EOF |-> tok_item.last)
    else $error("end of file token not marked last");

endmodule
